// ===== design/eis_pkg.sv =====
// shared types and constants for the endpoint insertion sorter
package eis_pkg;

   localparam int MAX_RECORDS_DEF = 64;

   localparam int POS_W = 16;
   localparam int HGT_W = 16;
   localparam int TAG_W = 6;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [HGT_W-1:0] hgt;
      logic [TAG_W-1:0] tag;
   } rec_type;

   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctl_type;

endpackage

// ===== design/eis_ifs.sv =====
// request and response channel interfaces of the endpoint insertion sorter
interface eis_req_if;
   import eis_pkg::*;
   logic             valid;
   logic             ready;
   logic             op;
   logic [POS_W-1:0] left_position;
   logic [POS_W-1:0] right_position;
   logic [HGT_W-1:0] height;
   logic [TAG_W-1:0] tag;

   modport source (output valid, op, left_position, right_position, height, tag, input ready);
   modport sink   (input valid, op, left_position, right_position, height, tag, output ready);
endinterface

interface eis_rsp_if;
   import eis_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] position;
   logic [HGT_W-1:0] rec_height;
   logic [TAG_W-1:0] rec_tag;
   logic             is_empty;
   logic             is_last;
   logic             overflowed;

   modport source (output valid, position, rec_height, rec_tag, is_empty, is_last, overflowed,
                   input ready);
   modport sink   (input valid, position, rec_height, rec_tag, is_empty, is_last, overflowed,
                   output ready);
endinterface

// ===== design/eis_cell.sv =====
// one slot of the sorted record chain
module eis_cell (
   input  logic                  clock,
   input  eis_pkg::cell_ctl_type ctl,
   input  logic                  occupied,
   input  eis_pkg::rec_type      new_rec,
   input  eis_pkg::rec_type      prev_rec,
   input  logic                  prev_precedes,
   input  eis_pkg::rec_type      next_rec,
   output eis_pkg::rec_type      rec,
   output logic                  precedes
);
   import eis_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;

   // strict compare keeps equal keys behind the stored ones
   assign precedes = !occupied || (new_rec.pos < rec_ff.pos);

   always_comb begin
      rec_in = rec_ff;
      if (ctl.insert) begin
         if (precedes && !prev_precedes) begin
            rec_in = new_rec;
         end else if (precedes) begin
            rec_in = prev_rec;
         end
      end else if (ctl.drain) begin
         rec_in = next_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;
endmodule

// ===== design/endpoint_insertion_sorter.sv =====
// stable insertion sorter for building endpoint records, built as a chain of cells
// insert: the left record enters the chain at the accepting edge and the right record
//   in the cycle after, from the hold register (req ready drops once)
// drain: the popped record sits in the response register from the next cycle
// reset (synchronous, active high) clears the record count, the overflow flag, the
//   pending right record and the response valid; record contents are not cleared
module endpoint_insertion_sorter #(
   parameter int MAX_RECORDS = eis_pkg::MAX_RECORDS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   eis_req_if.sink   req_chan,
   eis_rsp_if.source rsp_chan
);
   import eis_pkg::*;

   localparam int CNT_W = $clog2(MAX_RECORDS + 1);

   // occupancy and sticky overflow
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;

   // second half of an insert, held for one cycle
   logic             pend_right_ff, pend_right_in;
   rec_type          right_ff, right_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   rec_type          out_rec_ff, out_rec_in;
   logic             out_empty_ff, out_empty_in;
   logic             out_last_ff, out_last_in;
   logic             out_ovf_ff, out_ovf_in;

   logic             accept;
   logic             room;
   logic             start_insert;
   logic             start_drain;
   cell_ctl_type     ctl;
   rec_type          new_rec;

   rec_type          rec_w      [MAX_RECORDS];
   logic             precedes_w [MAX_RECORDS];

   // next request waits for the pending right record and a free response slot
   assign req_chan.ready = !pend_right_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   // a building needs two free slots
   assign room = ({1'b0, count_ff} + (CNT_W+1)'(2)) <= (CNT_W+1)'(MAX_RECORDS);

   assign start_insert = accept && (req_chan.op == OP_INSERT) && room;
   assign start_drain  = accept && (req_chan.op == OP_DRAIN) && (count_ff != '0);

   assign ctl.insert = start_insert || pend_right_ff;
   assign ctl.drain  = start_drain;

   // left record from the request, right record from the hold register
   always_comb begin
      if (pend_right_ff) begin
         new_rec = right_ff;
      end else begin
         new_rec.pos = req_chan.left_position;
         new_rec.hgt = req_chan.height;
         new_rec.tag = req_chan.tag;
      end
   end

   // the chain: cell 0 holds the smallest key
   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      logic    occ;
      logic    pb;
      rec_type pr;
      rec_type nr;

      assign occ = CNT_W'(i) < count_ff;

      if (i == 0) begin : g_head
         assign pb = 1'b0;
         assign pr = new_rec;
      end else begin : g_mid
         assign pb = precedes_w[i-1];
         assign pr = rec_w[i-1];
      end

      if (i == MAX_RECORDS - 1) begin : g_tail
         assign nr = rec_w[i];
      end else begin : g_body
         assign nr = rec_w[i+1];
      end

      eis_cell u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .occupied      (occ),
         .new_rec       (new_rec),
         .prev_rec      (pr),
         .prev_precedes (pb),
         .next_rec      (nr),
         .rec           (rec_w[i]),
         .precedes      (precedes_w[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      pend_right_in = 1'b0;
      right_in      = right_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_rec_in    = out_rec_ff;
      out_empty_in  = out_empty_ff;
      out_last_in   = out_last_ff;
      out_ovf_in    = out_ovf_ff;

      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (start_insert) begin
         pend_right_in = 1'b1;
         right_in.pos  = req_chan.right_position;
         right_in.hgt  = req_chan.height;
         right_in.tag  = req_chan.tag;
      end

      // dropped building sets the sticky flag
      if (accept && (req_chan.op == OP_INSERT) && !room) begin
         overflow_in = 1'b1;
      end

      if (accept && (req_chan.op == OP_DRAIN)) begin
         rsp_valid_in = 1'b1;
         out_ovf_in   = overflow_ff;
         if (count_ff == '0) begin
            out_rec_in   = '0;
            out_empty_in = 1'b1;
            out_last_in  = 1'b0;
         end else begin
            out_rec_in   = rec_w[0];
            out_empty_in = 1'b0;
            out_last_in  = (count_ff == CNT_W'(1));
            count_in     = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         pend_right_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         pend_right_ff <= pend_right_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      right_ff     <= right_in;
      out_rec_ff   <= out_rec_in;
      out_empty_ff <= out_empty_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.position   = out_rec_ff.pos;
   assign rsp_chan.rec_height = out_rec_ff.hgt;
   assign rsp_chan.rec_tag    = out_rec_ff.tag;
   assign rsp_chan.is_empty   = out_empty_ff;
   assign rsp_chan.is_last    = out_last_ff;
   assign rsp_chan.overflowed = out_ovf_ff;

`ifndef SYNTHESIS
   // occupancy never passes the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECORDS))
      else $error("record count beyond chain length");

   // the right record always finds a free slot
   a_pend_room: assert property (@(posedge clock) disable iff (reset)
      pend_right_ff |-> (count_ff < CNT_W'(MAX_RECORDS)))
      else $error("pending right record without a free slot");

   // an insert holds the request side for exactly one cycle
   a_pend_once: assert property (@(posedge clock) disable iff (reset)
      start_insert |=> (pend_right_ff && !req_chan.ready) ##1 !pend_right_ff)
      else $error("insert sequencing broken");

   // every drain produces a response
   a_drain_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.op == OP_DRAIN)) |=> rsp_valid_ff)
      else $error("drain without response");

   // the two front cells stay ordered
   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (rec_w[0].pos <= rec_w[1].pos))
      else $error("front of chain out of order");
`endif
endmodule

// ===== bench/tb_endpoint_insertion_sorter.sv =====
// self-checking testbench for the endpoint insertion sorter
module tb_endpoint_insertion_sorter;
   import eis_pkg::*;

   localparam int          DEPTH        = MAX_RECORDS_DEF;
   localparam int          RANDOM_ITEMS = 1000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int unsigned LIMIT_CYCLES = 500000;
   localparam int          SETTLE       = 20;

   // one request transaction as the sender offers it
   typedef struct packed {
      logic             op;
      logic [POS_W-1:0] lp;
      logic [POS_W-1:0] rp;
      logic [HGT_W-1:0] hgt;
      logic [TAG_W-1:0] tag;
   } bldg_req_type;

   // one popped record as the response channel carries it
   typedef struct packed {
      rec_type rec;
      logic    is_empty;
      logic    is_last;
      logic    overflowed;
   } popped_type;

   // sorted store predictor and pop checker
   class sorted_store_model;
      rec_type     store [DEPTH];
      int unsigned n_stored;
      bit          ovf;
      popped_type  pending_pops [$];
      int          errors;

      function new();
         n_stored = 0;
         ovf      = 0;
         errors   = 0;
      endfunction

      // stable placement: the new record lands after every key <= its own
      function void insert_sorted(logic [POS_W-1:0] key, logic [HGT_W-1:0] h,
                                  logic [TAG_W-1:0] t);
         int unsigned at;
         at = n_stored;
         while (at > 0 && store[at-1].pos > key) begin
            store[at] = store[at-1];
            at--;
         end
         store[at].pos = key;
         store[at].hgt = h;
         store[at].tag = t;
         n_stored++;
      endfunction

      function void apply_request(bldg_req_type it);
         popped_type res;
         res = '0;
         if (it.op == OP_INSERT) begin
            // a building needs two free slots, otherwise it is dropped whole
            if (n_stored + 2 > DEPTH) begin
               ovf = 1'b1;
            end else begin
               insert_sorted(it.lp, it.hgt, it.tag);
               insert_sorted(it.rp, it.hgt, it.tag);
            end
            return;
         end
         res.overflowed = ovf;
         if (n_stored == 0) begin
            res.is_empty = 1'b1;
         end else begin
            res.rec     = store[0];
            res.is_last = (n_stored == 1);
            for (int i = 1; i < n_stored; i++) store[i-1] = store[i];
            n_stored--;
         end
         pending_pops = {pending_pops, res};
      endfunction

      function int pending();
         return pending_pops.size();
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_pop(input popped_type got);
         popped_type want;
         if (pending_pops.size() == 0) begin
            report("response transaction with nothing expected");
            return;
         end
         want = pending_pops.pop_front();
         if (got.rec.pos !== want.rec.pos)
            report($sformatf("position got %0d want %0d", got.rec.pos, want.rec.pos));
         if (got.rec.hgt !== want.rec.hgt)
            report($sformatf("rec_height got %0d want %0d", got.rec.hgt, want.rec.hgt));
         if (got.rec.tag !== want.rec.tag)
            report($sformatf("rec_tag got %0d want %0d", got.rec.tag, want.rec.tag));
         if (got.is_empty !== want.is_empty)
            report($sformatf("is_empty got %b want %b", got.is_empty, want.is_empty));
         if (got.is_last !== want.is_last)
            report($sformatf("is_last got %b want %b", got.is_last, want.is_last));
         if (got.overflowed !== want.overflowed)
            report($sformatf("overflowed got %b want %b", got.overflowed, want.overflowed));
      endtask
   endclass

   logic clock;
   logic reset;

   eis_req_if req_chan ();
   eis_rsp_if rsp_chan ();

   endpoint_insertion_sorter #(
      .MAX_RECORDS(DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sorted_store_model model;

   int unsigned cycle_count = 0;
   int          sent        = 0;    // accepted request transactions
   bit          no_idle     = 0;    // both sides run back to back while set
   bit          hold_rsp    = 0;    // asks the receiver for one long hold-off
   bit          fill_done   = 0;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_endpoint_insertion_sorter: FAIL");
         $finish;
      end
   end

   // idle length: mostly none, often a few cycles, rarely a long gap
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // positions lean toward both ends of the range so equal keys are common
   function automatic logic [POS_W-1:0] rand_pos();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return POS_W'($urandom_range(0, 65535));
      if (r < 72) return POS_W'($urandom_range(0, 7));
      if (r < 86) return $urandom_range(0, 1) ? '1 : '0;
      return POS_W'($urandom_range(65528, 65535));
   endfunction

   function automatic logic [HGT_W-1:0] rand_hgt();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return HGT_W'($urandom_range(0, 65535));
      return $urandom_range(0, 1) ? '1 : '0;
   endfunction

   // receiver: random back-pressure plus the one long hold-off on request
   initial begin : receiver
      int unsigned stall_left;
      int unsigned len;
      popped_type  got;
      stall_left    = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp   = 0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            len = idle_length();
            if (len == 0) begin
               rsp_chan.ready = 1'b1;
            end else begin
               rsp_chan.ready = 1'b0;
               stall_left     = len - 1;
            end
         end
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1 && !reset) begin
            got.rec.pos    = rsp_chan.position;
            got.rec.hgt    = rsp_chan.rec_height;
            got.rec.tag    = rsp_chan.rec_tag;
            got.is_empty   = rsp_chan.is_empty;
            got.is_last    = rsp_chan.is_last;
            got.overflowed = rsp_chan.overflowed;
            model.check_pop(got);
         end
      end
   end

   // offer one transaction at the falling edge, hold it until accepted
   task automatic send_item(input bldg_req_type it);
      @(negedge clock);
      req_chan.valid          = 1'b1;
      req_chan.op             = it.op;
      req_chan.left_position  = it.lp;
      req_chan.right_position = it.rp;
      req_chan.height         = it.hgt;
      req_chan.tag            = it.tag;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      model.apply_request(it);
      sent++;
   endtask

   // drop valid for a random number of cycles, or not at all
   task automatic idle_req();
      int unsigned n;
      n = idle_length();
      if (n > 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_building_at(input logic [POS_W-1:0] lp, input logic [POS_W-1:0] rp,
                                   input logic [HGT_W-1:0] h, input logic [TAG_W-1:0] t);
      bldg_req_type it;
      it.op  = OP_INSERT;
      it.lp  = lp;
      it.rp  = rp;
      it.hgt = h;
      it.tag = t;
      send_item(it);
      idle_req();
   endtask

   task automatic send_building();
      send_building_at(rand_pos(), rand_pos(), rand_hgt(), TAG_W'($urandom_range(0, 63)));
   endtask

   // drain with random don't-care payload
   task automatic send_drain();
      bldg_req_type it;
      it.op  = OP_DRAIN;
      it.lp  = rand_pos();
      it.rp  = rand_pos();
      it.hgt = rand_hgt();
      it.tag = TAG_W'($urandom_range(0, 63));
      send_item(it);
      idle_req();
   endtask

   // keep the store short of overflow until the dedicated fill phase
   task automatic grow();
      if (!fill_done && model.n_stored + 2 > DEPTH) send_drain();
      else send_building();
   endtask

   task automatic drain_out();
      while (model.n_stored > 0) send_drain();
      repeat ($urandom_range(0, 2)) send_drain();
   endtask

   task automatic mixed_run(input int n);
      repeat (n) begin
         if ($urandom_range(0, 1)) grow();
         else send_drain();
      end
   endtask

   initial begin : stimulus
      bit hold_done;
      bit pause_done;
      int unsigned pick;
      hold_done  = 0;
      pause_done = 0;
      model      = new();

      // every input at a known value before the first edge
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.op             = OP_INSERT;
      req_chan.left_position  = '0;
      req_chan.right_position = '0;
      req_chan.height         = '0;
      req_chan.tag            = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty drain, extremes, equal keys, reversed edges
      send_drain();
      send_building_at('1, '0, '1, '1);
      send_building_at('0, '1, '0, '0);
      send_building_at(16'd100, 16'd100, 16'hAAAA, 6'h2A);
      send_building_at(16'h5555, 16'hAAAA, 16'h5555, 6'h15);
      send_building_at(16'd100, 16'd0, 16'h1234, 6'h01);
      repeat (11) send_drain();
      send_building_at(16'd7, 16'd7, 16'h00FF, 6'h3F);
      send_drain();
      send_building_at(16'd3, 16'd9, 16'hFF00, 6'h20);
      send_drain();
      send_drain();
      send_drain();

      // random phases
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (!hold_done && sent > 200) begin
            // receiver stalls long while requests keep coming
            hold_done = 1;
            hold_rsp  = 1;
            no_idle   = 1;
            repeat (4) grow();
            repeat (8) send_drain();
            no_idle   = 0;
         end else if (!pause_done && sent > 400) begin
            // sender waits for every expected pop before going on
            pause_done = 1;
            @(negedge clock);
            req_chan.valid = 1'b0;
            while (model.pending() != 0) @(posedge clock);
            idle_req();
         end else if (!fill_done && sent > 650) begin
            // fill exactly, then overflow at full and at one free slot
            fill_done = 1;
            if (model.n_stored % 2 != 0) send_drain();
            while (model.n_stored + 2 <= DEPTH) send_building();
            send_building();
            send_drain();
            send_building();
            send_building();
            drain_out();
         end else if (pick < 40) begin
            repeat ($urandom_range(1, 12)) grow();
            repeat ($urandom_range(0, 16)) send_drain();
         end else if (pick < 70) begin
            mixed_run(20);
         end else if (pick < 85) begin
            drain_out();
         end else begin
            no_idle = 1;
            mixed_run(30);
            no_idle = 0;
         end
      end
      drain_out();

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (model.errors == 0 && model.pending() == 0) begin
         $display("tb_endpoint_insertion_sorter: PASS");
      end else begin
         $display("tb_endpoint_insertion_sorter: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/eis_pkg.sv
design/eis_ifs.sv
design/eis_cell.sv
design/endpoint_insertion_sorter.sv
bench/tb_endpoint_insertion_sorter.sv
